// File: hdl/tpq_pkg.sv
// shared types and constants of the task priority queue
package tpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W    = 17;
  localparam int IN_ID_W = 10;
  localparam int PRI_W   = 8;
  localparam int DUR_W   = 16;
  localparam int RES_W   = 8;
  localparam int SPL_W   = 5;

  localparam logic [RES_W-1:0] SPLIT_THRESHOLD_RST = 8'd5;
  localparam int               SPLIT_ID_MUL        = 100;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [2:0] {
    STAT_PUSHED     = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_DISPATCHED = 3'd2,
    STAT_EMPTY      = 3'd3,
    STAT_UNSPLIT    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_APP0,
    S_APP1
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] priority_lvl;
    logic             critical;
    logic [DUR_W-1:0] duration;
    logic [RES_W-1:0] resources;
    logic             split;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } cand_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] sel;
    logic [CNT_W-1:0] count;
    entry_t           wdata;
  } cell_ctl_t;

  typedef struct packed {
    status_t          status;
    entry_t           entry;
    logic [SPL_W-1:0] splits;
  } result_t;

endpackage

// File: hdl/tpq_cell.sv
// one queue slot: stores a task and passes the best candidate toward the head
module tpq_cell import tpq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctl_t        ctl,
  input  entry_t           next_entry,
  input  cand_t            cand_in,
  output entry_t           entry,
  output cand_t            cand
);

  logic        own_valid;
  logic [24:0] own_key;
  logic [24:0] in_key;
  cand_t       cand_next;

  // lower key ranks better: priority, then critical, then duration
  assign own_key   = {entry.priority_lvl, ~entry.critical, entry.duration};
  assign in_key    = {cand_in.entry.priority_lvl, ~cand_in.entry.critical,
                      cand_in.entry.duration};
  assign own_valid = CNT_W'(cell_idx) < ctl.count;

  // on a tie the own slot wins, it is older than anything behind it
  always_comb begin
    if (!own_valid) begin
      cand_next = cand_in;
    end else if (cand_in.valid && (in_key < own_key)) begin
      cand_next = cand_in;
    end else begin
      cand_next = '{valid: 1'b1, idx: cell_idx, entry: entry};
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_APPEND: begin
        if (ctl.sel == cell_idx) begin
          entry <= ctl.wdata;
        end
      end
      CELL_REMOVE: begin
        if (cell_idx >= ctl.sel) begin
          entry <= next_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand.valid <= 1'b0;
    end else begin
      cand.valid <= cand_next.valid;
    end
    cand.idx   <= cand_next.idx;
    cand.entry <= cand_next.entry;
  end

endmodule

// File: hdl/tpq_ctrl.sv
// sequencer: push, search passes, splitting and dispatch
module tpq_ctrl import tpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               kind,
  input  logic [IN_ID_W-1:0] task_id,
  input  logic [PRI_W-1:0]   priority_req,
  input  logic               critical,
  input  logic [DUR_W-1:0]   duration,
  input  logic [RES_W-1:0]   resources,
  input  logic               split_threshold_we,
  input  logic [RES_W-1:0]   split_threshold_wdata,
  input  cand_t              best,
  output cell_ctl_t          ctl,
  output logic               busy,
  output logic               done,
  output result_t            res
);

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] count, count_next;
  logic [SPL_W-1:0] splits, splits_next;
  entry_t           cur, cur_next;
  logic [RES_W-1:0] threshold;
  logic             done_next;
  result_t          res_next;
  logic [23:0]      id_scaled;
  entry_t           half;
  logic             split_go;

  assign id_scaled = 24'(cur.id) * 24'(SPLIT_ID_MUL);
  assign split_go  = (best.entry.resources > threshold) && !best.entry.split;

  always_comb begin
    half           = cur;
    half.id        = id_scaled[ID_W-1:0];
    half.duration  = cur.duration >> 1;
    half.resources = cur.resources >> 1;
    half.split     = 1'b1;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    count_next  = count;
    splits_next = splits;
    cur_next    = cur;
    done_next   = 1'b0;
    res_next    = '{status: STAT_PUSHED, entry: '0, splits: '0};
    ctl         = '{op: CELL_HOLD, sel: '0, count: count, wdata: '0};
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_PUSH) begin
            done_next = 1'b1;
            if (count < CNT_W'(QUEUE_DEPTH)) begin
              ctl.op    = CELL_APPEND;
              ctl.sel   = count[IDX_W-1:0];
              ctl.wdata = '{id: ID_W'(task_id), priority_lvl: priority_req,
                            critical: critical, duration: duration,
                            resources: resources, split: 1'b0};
              count_next = count + 1'b1;
            end else begin
              res_next.status = STAT_FULL;
            end
          end else begin
            splits_next = '0;
            cnt_next    = '0;
            state_next  = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // the candidate ripples through every cell, registered in each, to reach the head
        cnt_next = cnt + 1'b1;
        if (cnt == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (count == '0) begin
          done_next       = 1'b1;
          res_next.status = STAT_EMPTY;
          res_next.splits = splits;
          state_next      = S_IDLE;
        end else begin
          ctl.op     = CELL_REMOVE;
          ctl.sel    = best.idx;
          count_next = count - 1'b1;
          if (split_go && (count < CNT_W'(QUEUE_DEPTH))) begin
            cur_next   = best.entry;
            state_next = S_APP0;
          end else begin
            done_next       = 1'b1;
            res_next.status = split_go ? STAT_UNSPLIT : STAT_DISPATCHED;
            res_next.entry  = best.entry;
            res_next.splits = splits;
            state_next      = S_IDLE;
          end
        end
      end
      S_APP0: begin
        ctl.op     = CELL_APPEND;
        ctl.sel    = count[IDX_W-1:0];
        ctl.wdata  = half;
        count_next = count + 1'b1;
        state_next = S_APP1;
      end
      S_APP1: begin
        ctl.op       = CELL_APPEND;
        ctl.sel      = count[IDX_W-1:0];
        ctl.wdata    = half;
        ctl.wdata.id = half.id + 1'b1;
        count_next   = count + 1'b1;
        splits_next  = splits + 1'b1;
        cnt_next     = '0;
        state_next   = S_SEARCH;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      threshold <= SPLIT_THRESHOLD_RST;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (split_threshold_we) begin
        threshold <= split_threshold_wdata;
      end
    end
    cnt    <= cnt_next;
    splits <= splits_next;
    cur    <= cur_next;
    if (done_next) begin
      res <= res_next;
    end
  end

endmodule

// File: hdl/task_priority_queue_with_split.sv
// top level: task priority queue built as a row of slot cells
//
//  channel   signals                                  handshake
//  request   kind task_id priority_req critical ...   start & !busy
//  result    status out_id ... splits_done            done, one cycle
//  config    split_threshold_wdata                    split_threshold_we
//
// a push is handled in the idle state; its result shows in the next cycle and busy stays low.
// a pop runs one selection pass, plus one more for each split: each selection pass lets the best
// candidate ripple through all 16 cells, a split adds a remove and two appends.
// reset empties the queue and sets the split threshold to 5.
// results are strobed by done for one cycle and cannot be held off.
module task_priority_queue_with_split import tpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [IN_ID_W-1:0] task_id,
  input  logic [PRI_W-1:0]   priority_req,
  input  logic               critical,
  input  logic [DUR_W-1:0]   duration,
  input  logic [RES_W-1:0]   resources,
  input  logic               split_threshold_we,
  input  logic [RES_W-1:0]   split_threshold_wdata,
  output logic               done,
  output logic [2:0]         status,
  output logic [ID_W-1:0]    out_id,
  output logic [PRI_W-1:0]   out_priority,
  output logic               out_critical,
  output logic [DUR_W-1:0]   out_duration,
  output logic [RES_W-1:0]   out_resources,
  output logic               out_was_split,
  output logic [SPL_W-1:0]   splits_done
);

  cell_ctl_t ctl;
  result_t   res;
  entry_t    entries [QUEUE_DEPTH];
  cand_t     cands   [QUEUE_DEPTH];

  tpq_ctrl u_ctrl (
    .clk                   (clk),
    .rst                   (rst),
    .start                 (start),
    .kind                  (kind),
    .task_id               (task_id),
    .priority_req          (priority_req),
    .critical              (critical),
    .duration              (duration),
    .resources             (resources),
    .split_threshold_we    (split_threshold_we),
    .split_threshold_wdata (split_threshold_wdata),
    .best                  (cands[0]),
    .ctl                   (ctl),
    .busy                  (busy),
    .done                  (done),
    .res                   (res)
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t next_entry;
    cand_t  cand_in;
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_entry = entries[i];
      assign cand_in    = '0;
    end else begin : g_body
      assign next_entry = entries[i+1];
      assign cand_in    = cands[i+1];
    end
    tpq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_idx   (IDX_W'(i)),
      .ctl        (ctl),
      .next_entry (next_entry),
      .cand_in    (cand_in),
      .entry      (entries[i]),
      .cand       (cands[i])
    );
  end

  assign status        = res.status;
  assign out_id        = res.entry.id;
  assign out_priority  = res.entry.priority_lvl;
  assign out_critical  = res.entry.critical;
  assign out_duration  = res.entry.duration;
  assign out_resources = res.entry.resources;
  assign out_was_split = res.entry.split;
  assign splits_done   = res.splits;

endmodule

// File: tb/tb_task_priority_queue_with_split.sv
// self-checking testbench of the task priority queue with splitting
`timescale 1ns / 100ps

module tb_task_priority_queue_with_split;
  import tpq_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 40;

  // mirrors the queue contents and checks every dispatch and push reply
  class dispatch_tracker;
    entry_t           slots[QUEUE_DEPTH];
    int               fill;
    logic [RES_W-1:0] threshold;
    result_t          awaited[$];
    int               failures;

    function new();
      fill      = 0;
      threshold = SPLIT_THRESHOLD_RST;
      failures  = 0;
    endfunction

    function void add_slot(entry_t e);
      if (fill < QUEUE_DEPTH) begin
        slots[fill] = e;
        fill++;
      end
    endfunction

    function void drop_slot(int k);
      for (int i = k; i < fill - 1; i++) slots[i] = slots[i + 1];
      fill--;
    endfunction

    function bit outranks(entry_t a, entry_t b);
      if (a.priority_lvl != b.priority_lvl) return a.priority_lvl < b.priority_lvl;
      if (a.critical != b.critical) return a.critical;
      return a.duration < b.duration;
    endfunction

    // select, split while allowed, then dispatch
    function result_t run_pop();
      result_t          r;
      entry_t           t;
      entry_t           h;
      int               best;
      logic [SPL_W-1:0] nsplit;
      r      = '0;
      nsplit = '0;
      for (int guard = 0; guard <= 2 * QUEUE_DEPTH + 2; guard++) begin
        if (fill == 0) begin
          r.status = STAT_EMPTY;
          r.splits = nsplit;
          return r;
        end
        best = 0;
        for (int i = 1; i < fill; i++) if (outranks(slots[i], slots[best])) best = i;
        t = slots[best];
        r.status = STAT_DISPATCHED;
        if (t.resources > threshold && !t.split) begin
          if (fill < QUEUE_DEPTH) begin
            drop_slot(best);
            h           = t;
            h.duration  = t.duration >> 1;
            h.resources = t.resources >> 1;
            h.split     = 1'b1;
            h.id        = ID_W'(t.id * SPLIT_ID_MUL);
            add_slot(h);
            h.id        = ID_W'(t.id * SPLIT_ID_MUL + 1);
            add_slot(h);
            nsplit++;
            continue;
          end
          // no free slot for the second half
          r.status = STAT_UNSPLIT;
        end
        drop_slot(best);
        r.entry  = t;
        r.splits = nsplit;
        return r;
      end
      r.status = STAT_EMPTY;
      r.splits = nsplit;
      return r;
    endfunction

    function void note_request(logic k, entry_t e);
      result_t r;
      r = '0;
      if (k == KIND_PUSH) begin
        if (fill >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          add_slot(e);
          r.status = STAT_PUSHED;
        end
      end else begin
        r = run_pop();
      end
      awaited = {awaited, r};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $error("reply with status %0d while none is outstanding", got.status);
        failures++;
        return;
      end
      want = awaited.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("out_id", 32'(want.entry.id), 32'(got.entry.id));
      compare_field("out_priority", 32'(want.entry.priority_lvl), 32'(got.entry.priority_lvl));
      compare_field("out_critical", 32'(want.entry.critical), 32'(got.entry.critical));
      compare_field("out_duration", 32'(want.entry.duration), 32'(got.entry.duration));
      compare_field("out_resources", 32'(want.entry.resources), 32'(got.entry.resources));
      compare_field("out_was_split", 32'(want.entry.split), 32'(got.entry.split));
      compare_field("splits_done", 32'(want.splits), 32'(got.splits));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic               kind;
  logic [IN_ID_W-1:0] task_id;
  logic [PRI_W-1:0]   priority_req;
  logic               critical;
  logic [DUR_W-1:0]   duration;
  logic [RES_W-1:0]   resources;
  logic               split_threshold_we;
  logic [RES_W-1:0]   split_threshold_wdata;
  logic               done;
  logic [2:0]         status;
  logic [ID_W-1:0]    out_id;
  logic [PRI_W-1:0]   out_priority;
  logic               out_critical;
  logic [DUR_W-1:0]   out_duration;
  logic [RES_W-1:0]   out_resources;
  logic               out_was_split;
  logic [SPL_W-1:0]   splits_done;

  dispatch_tracker sb = new();
  int              cycles = 0;
  bit              steady = 1'b0;
  result_t         seen;

  task_priority_queue_with_split dut (
    .clk                   (clk),
    .rst                   (rst),
    .start                 (start),
    .busy                  (busy),
    .kind                  (kind),
    .task_id               (task_id),
    .priority_req          (priority_req),
    .critical              (critical),
    .duration              (duration),
    .resources             (resources),
    .split_threshold_we    (split_threshold_we),
    .split_threshold_wdata (split_threshold_wdata),
    .done                  (done),
    .status                (status),
    .out_id                (out_id),
    .out_priority          (out_priority),
    .out_critical          (out_critical),
    .out_duration          (out_duration),
    .out_resources         (out_resources),
    .out_was_split         (out_was_split),
    .splits_done           (splits_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("task_priority_queue_with_split regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      seen.status             = status_t'(status);
      seen.entry.id           = out_id;
      seen.entry.priority_lvl = out_priority;
      seen.entry.critical     = out_critical;
      seen.entry.duration     = out_duration;
      seen.entry.resources    = out_resources;
      seen.entry.split        = out_was_split;
      seen.splits             = splits_done;
      sb.check_reply(seen);
    end
  end

  task automatic send_item(input logic k, input logic [IN_ID_W-1:0] id,
                           input logic [PRI_W-1:0] pri, input logic crit,
                           input logic [DUR_W-1:0] dur, input logic [RES_W-1:0] res);
    int     gap;
    entry_t e;
    gap = (!steady && $urandom_range(99) < 20) ? $urandom_range(4, 1) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    kind         <= k;
    task_id      <= id;
    priority_req <= pri;
    critical     <= crit;
    duration     <= dur;
    resources    <= res;
    do @(posedge clk); while (busy);
    e              = '0;
    e.id           = ID_W'(id);
    e.priority_lvl = pri;
    e.critical     = crit;
    e.duration     = dur;
    e.resources    = res;
    sb.note_request(k, e);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic set_split_threshold(input logic [RES_W-1:0] value);
    go_quiet();
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    split_threshold_we    <= 1'b1;
    split_threshold_wdata <= value;
    @(posedge clk);
    sb.threshold = value;
    @(negedge clk);
    split_threshold_we <= 1'b0;
  endtask

  // push with fields biased toward ties and toward the split boundary
  task automatic push_random();
    int               r;
    logic [PRI_W-1:0] pri;
    logic [DUR_W-1:0] dur;
    logic [RES_W-1:0] res;
    pri = ($urandom_range(99) < 70) ? PRI_W'($urandom_range(3)) : PRI_W'($urandom_range(255));
    dur = ($urandom_range(99) < 60) ? DUR_W'($urandom_range(7)) : DUR_W'($urandom_range(65535));
    r = $urandom_range(99);
    if (r < 40) begin
      r = int'(sb.threshold) + $urandom_range(2) - 1;
      if (r < 0) r = 0;
      if (r > 255) r = 255;
      res = RES_W'(r);
    end else if (r < 70) begin
      res = RES_W'($urandom_range(255));
    end else begin
      res = RES_W'($urandom_range(15));
    end
    send_item(KIND_PUSH, IN_ID_W'($urandom_range(1023)), pri, 1'($urandom_range(1)), dur, res);
  endtask

  task automatic run_phase(input logic [RES_W-1:0] thr, input int push_pct, input bit calm);
    set_split_threshold(thr);
    steady = calm;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(99) < push_pct) begin
        push_random();
      end else begin
        // pop carries noise in the unused fields
        send_item(KIND_POP, IN_ID_W'($urandom_range(1023)), PRI_W'($urandom_range(255)),
                  1'($urandom_range(1)), DUR_W'($urandom_range(65535)),
                  RES_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst                   = 1'b1;
    start                 = 1'b0;
    kind                  = KIND_PUSH;
    task_id               = '0;
    priority_req          = '0;
    critical              = 1'b0;
    duration              = '0;
    resources             = '0;
    split_threshold_we    = 1'b0;
    split_threshold_wdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset threshold
    send_item(KIND_POP, '0, '0, 1'b0, '0, '0);
    send_item(KIND_PUSH, 10'd1023, 8'd255, 1'b1, 16'hFFFF, 8'd255);
    send_item(KIND_PUSH, 10'd0, 8'd0, 1'b0, 16'd0, 8'd0);
    send_item(KIND_POP, '0, '0, 1'b0, '0, '0);
    // large task splits into halves that are never split again
    send_item(KIND_POP, '0, '0, 1'b0, '0, '0);
    send_item(KIND_POP, '0, '0, 1'b0, '0, '0);
    send_item(KIND_POP, '0, '0, 1'b0, '0, '0);
    // fill with ties on priority, critical and duration, then overflow
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_item(KIND_PUSH, IN_ID_W'(100 + i), 8'd3, 1'(i), DUR_W'(i % 3), 8'd6);
    send_item(KIND_PUSH, 10'd555, 8'd0, 1'b1, 16'd0, 8'd0);
    // full queue: best task goes out whole
    send_item(KIND_POP, '0, '0, 1'b0, '0, '0);

    run_phase(8'd0, 55, 1'b0);
    run_phase(8'd255, 65, 1'b0);
    run_phase(8'd5, 60, 1'b1);
    run_phase(RES_W'($urandom_range(255)), 50, 1'b0);
    run_phase(8'd1, 70, 1'b0);
    run_phase(8'd128, 40, 1'b0);
    run_phase(8'd3, 55, 1'b0);

    go_quiet();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("task_priority_queue_with_split regression: pass");
    end else begin
      $display("task_priority_queue_with_split regression: fail");
    end
    $finish;
  end

endmodule
